@@ hw/rtl/lbu_pkg.sv @@
// Shared constants and types for the letterbox box unscale unit.
// No dependencies; imported by every module of the unit.
`default_nettype none
package lbu_pkg;
    localparam int FRAC_BITS  = 4;
    localparam int DIM_W      = 13;
    localparam int COORD_W    = DIM_W + FRAC_BITS;
    localparam int INFER_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_W      = 33;
    // num >= 0 is below 2^32; dividend is num / (2*2^FRAC_BITS)
    localparam int DVD_W      = NUM_W - 1 - (FRAC_BITS + 1);
    localparam int QUOT_W     = DIM_W + 1;
    localparam int LANES      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_INFER_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INFER_WIDTH  = 2'd1;

    typedef struct packed {
        logic             neg;
        logic [DVD_W-1:0] dividend;
    } t_lane;

    typedef struct packed {
        logic             neg;
        logic             sat;
        logic [QUOT_W-1:0] quot;
    } t_quot;
endpackage
`default_nettype wire

@@ hw/rtl/lbu_front.sv @@
// Front stages: input capture, axis choice, products and numerators.
// Depends on lbu_pkg.
`default_nettype none
module lbu_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire [lbu_pkg::INFER_W-1:0]   i_ih,
    input  wire [lbu_pkg::INFER_W-1:0]   i_iw,
    input  wire [lbu_pkg::DIM_W-1:0]     i_sh,
    input  wire [lbu_pkg::DIM_W-1:0]     i_sw,
    input  wire signed [lbu_pkg::COORD_W-1:0] i_c [lbu_pkg::LANES],
    output logic                         o_valid,
    output logic                         o_zero,
    output logic [lbu_pkg::DIM_W-1:0]    o_lim_x,
    output logic [lbu_pkg::DIM_W-1:0]    o_lim_y,
    output logic [lbu_pkg::INFER_W-1:0]  o_n,
    output lbu_pkg::t_lane               o_lane [lbu_pkg::LANES]
);
    import lbu_pkg::*;
    localparam int PW = INFER_W + DIM_W;
    localparam int CDW = COORD_W + DIM_W + 1;

    // stage A
    logic                 r_a_v, r_a_zero;
    logic [INFER_W-1:0]   r_a_ih, r_a_iw;
    logic [DIM_W-1:0]     r_a_sh, r_a_sw;
    logic signed [COORD_W-1:0] r_a_c [LANES];
    // stage B
    logic                 r_b_v, r_b_zero;
    logic [INFER_W-1:0]   r_b_ih, r_b_iw;
    logic [DIM_W-1:0]     r_b_sh, r_b_sw;
    logic signed [COORD_W-1:0] r_b_c [LANES];
    logic [PW-1:0]        r_b_ph, r_b_pw;
    // stage C
    logic                 r_c_v, r_c_zero;
    logic [DIM_W-1:0]     r_c_sh, r_c_sw;
    logic [INFER_W-1:0]   r_c_n;
    logic signed [CDW-1:0] r_c_cd [LANES];
    logic [PW-1:0]        r_c_idx, r_c_idy, r_c_snx, r_c_sny;

    logic                 sel_h;
    logic [INFER_W-1:0]   n_sel;
    logic [DIM_W-1:0]     d_sel;
    logic signed [NUM_W-1:0] num [LANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            o_valid <= r_c_v;
        end
    end

    always_comb begin
        sel_h = (r_b_ph <= r_b_pw);
        n_sel = sel_h ? r_b_ih : r_b_iw;
        d_sel = sel_h ? r_b_sh : r_b_sw;
        for (int k = 0; k < LANES; k++) begin
            num[k] = (NUM_W'(r_c_cd[k]) <<< 1)
                   - (NUM_W'(signed'({1'b0, (k % 2 == 0) ? r_c_idx : r_c_idy})) <<< FRAC_BITS)
                   + (NUM_W'(signed'({1'b0, (k % 2 == 0) ? r_c_snx : r_c_sny})) <<< FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_zero <= (i_ih == '0) || (i_iw == '0) || (i_sh == '0) || (i_sw == '0);
        r_a_ih <= i_ih;
        r_a_iw <= i_iw;
        r_a_sh <= i_sh;
        r_a_sw <= i_sw;
        r_a_c  <= i_c;

        r_b_zero <= r_a_zero;
        r_b_ih <= r_a_ih;
        r_b_iw <= r_a_iw;
        r_b_sh <= r_a_sh;
        r_b_sw <= r_a_sw;
        r_b_c  <= r_a_c;
        r_b_ph <= PW'(r_a_ih * r_a_sw);
        r_b_pw <= PW'(r_a_iw * r_a_sh);

        r_c_zero <= r_b_zero;
        r_c_sh <= r_b_sh;
        r_c_sw <= r_b_sw;
        r_c_n  <= n_sel;
        for (int k = 0; k < LANES; k++) begin
            r_c_cd[k] <= CDW'(r_b_c[k] * signed'({1'b0, d_sel}));
        end
        r_c_idx <= PW'(r_b_iw * d_sel);
        r_c_idy <= PW'(r_b_ih * d_sel);
        r_c_snx <= PW'(r_b_sw * n_sel);
        r_c_sny <= PW'(r_b_sh * n_sel);

        o_zero  <= r_c_zero;
        o_lim_x <= r_c_sw - DIM_W'(1);
        o_lim_y <= r_c_sh - DIM_W'(1);
        o_n     <= r_c_n;
        for (int k = 0; k < LANES; k++) begin
            o_lane[k].neg      <= num[k][NUM_W-1];
            o_lane[k].dividend <= num[k][NUM_W-2:FRAC_BITS+1];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/lbu_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Depends on lbu_pkg.
`default_nettype none
module lbu_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire lbu_pkg::t_lane          i_lane,
    input  wire [lbu_pkg::INFER_W-1:0]   i_divisor,
    output logic                         o_valid,
    output lbu_pkg::t_quot               o_quot
);
    import lbu_pkg::*;

    logic                 r_v   [QUOT_W+1];
    logic                 r_neg [QUOT_W+1];
    logic                 r_sat [QUOT_W+1];
    logic [DVD_W-1:0]     r_rem [QUOT_W+1];
    logic [INFER_W-1:0]   r_dv  [QUOT_W+1];
    logic [QUOT_W-1:0]    r_q   [QUOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QUOT_W; s++) r_v[s] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= QUOT_W; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        // quotient too wide for QUOT_W bits: flag and clamp later
        r_sat[0] <= i_lane.dividend >= (DVD_W'(i_divisor) << QUOT_W);
        r_neg[0] <= i_lane.neg;
        r_rem[0] <= i_lane.dividend;
        r_dv[0]  <= i_divisor;
        r_q[0]   <= '0;
    end

    for (genvar s = 1; s <= QUOT_W; s++) begin : g_step
        logic [DVD_W-1:0] trial;
        logic             take;
        assign trial = DVD_W'(r_dv[s-1]) << (QUOT_W - s);
        assign take  = r_rem[s-1] >= trial;
        always_ff @(posedge i_clk) begin
            r_sat[s] <= r_sat[s-1];
            r_neg[s] <= r_neg[s-1];
            r_dv[s]  <= r_dv[s-1];
            r_rem[s] <= take ? r_rem[s-1] - trial : r_rem[s-1];
            r_q[s]   <= {r_q[s-1][QUOT_W-2:0], take};
        end
    end

    assign o_valid     = r_v[QUOT_W];
    assign o_quot.neg  = r_neg[QUOT_W];
    assign o_quot.sat  = r_sat[QUOT_W];
    assign o_quot.quot = r_q[QUOT_W];
endmodule
`default_nettype wire

@@ hw/rtl/letterbox_bbox_unscale_unit.sv @@
// Top level of the letterbox box unscale unit: config registers, four divider lanes, clamp.
// Depends on lbu_pkg, lbu_front, lbu_div.
//
//   channel  | ports                                           | timing
//   command  | i_start, o_busy, i_src_*, i_box_*               | beat when start & !busy
//   result   | o_valid, o_out_*                                | one cycle, no backpressure
//   config   | i_cfg_we, i_cfg_idx, i_cfg_data                 | write on we
//
// One box enters per cycle; o_busy is always low. The path holds
// four front stages, one divider setup stage, 14 quotient-bit stages and the
// clamp register. Reset sets both inference sizes to 640 and empties the pipe.
`default_nettype none
module letterbox_bbox_unscale_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    output logic                             o_busy,
    input  wire [lbu_pkg::DIM_W-1:0]         i_src_height,
    input  wire [lbu_pkg::DIM_W-1:0]         i_src_width,
    input  wire signed [lbu_pkg::COORD_W-1:0] i_box_left,
    input  wire signed [lbu_pkg::COORD_W-1:0] i_box_top,
    input  wire signed [lbu_pkg::COORD_W-1:0] i_box_right,
    input  wire signed [lbu_pkg::COORD_W-1:0] i_box_bottom,
    output logic                             o_valid,
    output logic [lbu_pkg::DIM_W-1:0]        o_out_left,
    output logic [lbu_pkg::DIM_W-1:0]        o_out_top,
    output logic [lbu_pkg::DIM_W-1:0]        o_out_right,
    output logic [lbu_pkg::DIM_W-1:0]        o_out_bottom,
    input  wire                              i_cfg_we,
    input  wire [lbu_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [lbu_pkg::INFER_W-1:0]       i_cfg_data
);
    import lbu_pkg::*;
    localparam int SB = QUOT_W + 1;

    logic [INFER_W-1:0] r_ih, r_iw;
    logic signed [COORD_W-1:0] coords [LANES];
    logic               f_valid, f_zero;
    logic [DIM_W-1:0]   f_lim_x, f_lim_y;
    logic [INFER_W-1:0] f_n;
    t_lane              f_lane [LANES];
    logic               d_valid [LANES];
    t_quot              d_quot  [LANES];
    logic               r_sb_zero [SB];
    logic [DIM_W-1:0]   r_sb_limx [SB];
    logic [DIM_W-1:0]   r_sb_limy [SB];
    logic [DIM_W-1:0]   res [LANES];

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ih <= INFER_W'(640);
            r_iw <= INFER_W'(640);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INFER_HEIGHT: r_ih <= i_cfg_data;
                CFG_INFER_WIDTH:  r_iw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign coords[0] = i_box_left;
    assign coords[1] = i_box_top;
    assign coords[2] = i_box_right;
    assign coords[3] = i_box_bottom;

    lbu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_start),
        .i_ih    (r_ih),
        .i_iw    (r_iw),
        .i_sh    (i_src_height),
        .i_sw    (i_src_width),
        .i_c     (coords),
        .o_valid (f_valid),
        .o_zero  (f_zero),
        .o_lim_x (f_lim_x),
        .o_lim_y (f_lim_y),
        .o_n     (f_n),
        .o_lane  (f_lane)
    );

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        lbu_div u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (f_valid),
            .i_lane    (f_lane[k]),
            .i_divisor (f_n),
            .o_valid   (d_valid[k]),
            .o_quot    (d_quot[k])
        );
    end

    // side band rides alongside the divider stages
    always_ff @(posedge i_clk) begin
        r_sb_zero[0] <= f_zero;
        r_sb_limx[0] <= f_lim_x;
        r_sb_limy[0] <= f_lim_y;
        for (int s = 1; s < SB; s++) begin
            r_sb_zero[s] <= r_sb_zero[s-1];
            r_sb_limx[s] <= r_sb_limx[s-1];
            r_sb_limy[s] <= r_sb_limy[s-1];
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            logic [DIM_W-1:0] lim;
            lim = (k % 2 == 0) ? r_sb_limx[SB-1] : r_sb_limy[SB-1];
            if (r_sb_zero[SB-1] || d_quot[k].neg) begin
                res[k] = '0;
            end else if (d_quot[k].sat || d_quot[k].quot > QUOT_W'(lim)) begin
                res[k] = lim;
            end else begin
                res[k] = d_quot[k].quot[DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= d_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_left   <= res[0];
        o_out_top    <= res[1];
        o_out_right  <= res[2];
        o_out_bottom <= res[3];
    end
endmodule
`default_nettype wire

@@ test/tb_letterbox_bbox_unscale_unit.sv @@
// Testbench for letterbox_bbox_unscale_unit: drives boxes, predicts source-pixel coordinates.
// Depends on lbu_pkg and the unit's RTL; a small scoreboard class holds expected boxes.
`default_nettype none
module tb_letterbox_bbox_unscale_unit;
    import lbu_pkg::*;

    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
    } t_src_box;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    class unscale_board;
        t_src_box expected_boxes[$];
        logic [INFER_W-1:0] ih = 640;
        logic [INFER_W-1:0] iw = 640;

        function automatic logic [DIM_W-1:0] map_coord(longint c, longint idim, longint sdim,
                                                       longint n, longint d);
            longint f;
            longint num;
            longint q;
            f = longint'(1) << FRAC_BITS;
            num = 2 * c * d - f * idim * d + f * sdim * n;
            if (num < 0) return '0;
            q = num / (2 * f * n);
            if (q > sdim - 1) q = sdim - 1;
            return q[DIM_W-1:0];
        endfunction

        function void note_box(logic [DIM_W-1:0] sh, logic [DIM_W-1:0] sw,
                               logic signed [COORD_W-1:0] x1, logic signed [COORD_W-1:0] y1,
                               logic signed [COORD_W-1:0] x2, logic signed [COORD_W-1:0] y2);
            t_src_box b;
            longint n;
            longint d;
            b = '0;
            if (sh != 0 && sw != 0 && ih != 0 && iw != 0) begin
                if (longint'(ih) * sw <= longint'(iw) * sh) begin
                    n = ih; d = sh;
                end else begin
                    n = iw; d = sw;
                end
                b.left   = map_coord(x1, iw, sw, n, d);
                b.top    = map_coord(y1, ih, sh, n, d);
                b.right  = map_coord(x2, iw, sw, n, d);
                b.bottom = map_coord(y2, ih, sh, n, d);
            end
            expected_boxes.push_back(b);
        endfunction

        task check_box(t_src_box got);
            t_src_box w;
            if (expected_boxes.size() == 0) begin
                report_mismatch("unexpected result", got.left, -1);
                return;
            end
            w = expected_boxes.pop_front();
            if (got.left   !== w.left)   report_mismatch("left", got.left, w.left);
            if (got.top    !== w.top)    report_mismatch("top", got.top, w.top);
            if (got.right  !== w.right)  report_mismatch("right", got.right, w.right);
            if (got.bottom !== w.bottom) report_mismatch("bottom", got.bottom, w.bottom);
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic o_busy;
    logic [DIM_W-1:0] i_src_height = 1;
    logic [DIM_W-1:0] i_src_width = 1;
    logic signed [COORD_W-1:0] i_box_left = 0;
    logic signed [COORD_W-1:0] i_box_top = 0;
    logic signed [COORD_W-1:0] i_box_right = 0;
    logic signed [COORD_W-1:0] i_box_bottom = 0;
    logic o_valid;
    logic [DIM_W-1:0] o_out_left, o_out_top, o_out_right, o_out_bottom;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_INFER_HEIGHT;
    logic [INFER_W-1:0] i_cfg_data = 0;

    unscale_board board = new();
    bit quiet_stretch = 0;

    letterbox_bbox_unscale_unit u_top (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            board.check_box({o_out_left, o_out_top, o_out_right, o_out_bottom});
    end

    task automatic write_infer(input logic [CFG_IDX_W-1:0] idx, input logic [INFER_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        if (idx == CFG_INFER_HEIGHT) board.ih = v;
        else board.iw = v;
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    // Present one box; hold start until the beat is taken.
    task automatic send_box(input logic [DIM_W-1:0] sh, input logic [DIM_W-1:0] sw,
                            input logic [COORD_W-1:0] x1, input logic [COORD_W-1:0] y1,
                            input logic [COORD_W-1:0] x2, input logic [COORD_W-1:0] y2);
        @(negedge i_clk);
        while (!quiet_stretch && $urandom_range(99) < 9) begin
            i_start = 0;
            @(negedge i_clk);
        end
        i_start = 1;
        i_src_height = sh; i_src_width = sw;
        i_box_left = x1; i_box_top = y1; i_box_right = x2; i_box_bottom = y2;
        do @(posedge i_clk); while (o_busy);
        board.note_box(sh, sw, x1, y1, x2, y2);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_start = 0;
        while (board.expected_boxes.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(5))
            0: return DIM_W'(1);
            1: return DIM_W'(8191);
            2: return DIM_W'($urandom_range(1, 8191));
            default: return DIM_W'($urandom_range(1, 2000));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(5))
            0: return 17'h10000;
            1: return 17'h0ffff;
            2: return COORD_W'($urandom());
            default: return COORD_W'($urandom_range(0, 16 * 1200));
        endcase
    endfunction

    task automatic random_boxes(input int count);
        for (int k = 0; k < count; k++)
            send_box(pick_dim(), pick_dim(), pick_coord(), pick_coord(),
                     pick_coord(), pick_coord());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // Directed: reset sizes, extremes of dims and coordinates, both gain axes.
        send_box(480, 640, 16 * 100, 16 * 100, 16 * 500, 16 * 400);
        send_box(640, 480, 16 * 100, 16 * 100, 16 * 500, 16 * 400);
        send_box(1, 1, 17'h10000, 17'h0ffff, 0, 17'h1ffff);
        send_box(8191, 8191, 17'h0ffff, 17'h10000, 17'h1ffff, 0);
        send_box(8191, 1, 17'h0ffff, 17'h0ffff, 17'h10000, 17'h10000);
        send_box(1, 8191, 17'h0ffff, 17'h0ffff, 17'h10000, 17'h10000);
        send_box(0, 100, 16 * 5, 16 * 5, 16 * 9, 16 * 9);
        send_box(100, 0, 16 * 5, 16 * 5, 16 * 9, 16 * 9);
        send_box(5461, 2730, 17'h15555, 17'h0aaaa, 17'h0aaaa, 17'h15555);
        send_box(720, 1280, 16 * 320, 16 * 140, 16 * 320, 16 * 500);
        drain();
        write_infer(CFG_INFER_HEIGHT, 4095);
        write_infer(CFG_INFER_WIDTH, 1);
        send_box(100, 100, 16, 16, 17'h0ffff, 17'h0ffff);
        send_box(8191, 8191, 0, 8, 17'h10000, 17'h0fff0);
        drain();
        write_infer(CFG_INFER_HEIGHT, 0);
        send_box(100, 100, 16, 16, 32, 32);
        drain();
        write_infer(CFG_INFER_HEIGHT, 1);
        write_infer(CFG_INFER_WIDTH, 4095);
        send_box(100, 100, 16, 16, 17'h0ffff, 17'h0ffff);
        drain();
        write_infer(CFG_INFER_WIDTH, 0);
        send_box(100, 100, 16, 16, 32, 32);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_infer(CFG_INFER_HEIGHT, ph == 0 ? 4095 : ph == 1 ? 1 :
                        INFER_W'($urandom_range(1, 4095)));
            write_infer(CFG_INFER_WIDTH, ph == 0 ? 4095 : ph == 1 ? 4095 :
                        INFER_W'($urandom_range(1, 4095)));
            quiet_stretch = (ph == 3);
            random_boxes(230);
            drain();
        end
        if (board.expected_boxes.size() != 0) n_errors++;
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
